[src/gpi_pkg.sv]
// ----------------------------------------------------------------------------
// gpi_pkg
// Shared types, codes and defaults for the galvo point interpolator.
// ----------------------------------------------------------------------------
package gpi_pkg;

    localparam int POINTS_DEF = 5;

    localparam logic [1:0] MODE_BYTE   = 2'd0;
    localparam logic [1:0] MODE_FIRE   = 2'd1;
    localparam logic [1:0] MODE_TOGGLE = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] x_value;
        logic [7:0] y_value;
        logic [7:0] laser_value;
    } t_out_beat;

    typedef struct packed {
        logic       strobe;
        logic       last;
        logic [7:0] data;
    } t_tbl_wr;

endpackage

[src/gpi_point_table.sv]
// ----------------------------------------------------------------------------
// gpi_point_table
// Packet byte staging and the committed table of output points, with the
// midpoints worked out at commit.
// ----------------------------------------------------------------------------
module gpi_point_table
    import gpi_pkg::*;
#(
    parameter int POINTS = POINTS_DEF,
    localparam int NBYTES = 3 * POINTS,
    localparam int NPOS = 2 * POINTS - 1,
    localparam int AW = $clog2(NPOS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_wr       i_wr,
    input  logic [AW-1:0] i_rd_addr,
    output t_out_beat     o_point
);

    localparam int BPW = $clog2(NBYTES + 1);
    localparam int SW  = $clog2(NBYTES);

    function automatic logic [7:0] mid8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    logic [7:0]     r_staged [NBYTES];
    logic [7:0]     n_staged [NBYTES];
    logic [BPW-1:0] r_pos;
    logic [BPW-1:0] n_pos;
    t_out_beat      r_table [NPOS];
    t_out_beat      n_table [NPOS];
    logic           room;

    assign room = (r_pos < BPW'(NBYTES));

    always_comb begin
        n_staged = r_staged;
        n_pos    = r_pos;
        if (i_wr.strobe && room) begin
            n_staged[r_pos[SW-1:0]] = i_wr.data;
            n_pos = r_pos + 1'b1;
        end
        if (i_wr.strobe && i_wr.last) begin
            n_pos = '0;
        end
    end

    always_comb begin
        for (int p = 0; p < POINTS; p++) begin
            n_table[2*p] = '{x_value:     n_staged[3*p],
                             y_value:     n_staged[3*p+1],
                             laser_value: n_staged[3*p+2]};
        end
        for (int p = 0; p < POINTS - 1; p++) begin
            n_table[2*p+1] = '{x_value:     mid8(n_staged[3*p], n_staged[3*p+3]),
                               y_value:     mid8(n_staged[3*p+1], n_staged[3*p+4]),
                               laser_value: n_staged[3*p+2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_staged <= '{default: '0};
            r_pos    <= '0;
            r_table  <= '{default: '0};
        end else begin
            r_staged <= n_staged;
            r_pos    <= n_pos;
            if (i_wr.strobe && i_wr.last) begin
                r_table <= n_table;
            end
        end
    end

    assign o_point = r_table[i_rd_addr];

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= BPW'(NBYTES))
        else $error("byte position beyond staging area");

    a_commit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.strobe && i_wr.last |=> r_pos == '0)
        else $error("byte position not cleared by commit");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.strobe && !i_wr.last && !room |=> $stable(r_pos))
        else $error("byte position moved past full packet");
`endif

endmodule

[src/galvo_point_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// galvo_point_interpolator_unit
// Packet staging, fire tick sequencing and point output for the galvo DACs.
// ----------------------------------------------------------------------------
// Latency: a point is registered and appears on o_out_valid in the cycle after its tick beat.
// Throughput: one beat per cycle; o_in_ready drops only while the output
// register holds a point not yet taken.
// Reset: synchronous, active low; clears staging, stores and counters and
// selects interpolated mode.
module galvo_point_interpolator_unit
    import gpi_pkg::*;
#(
    parameter int POINTS = POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    localparam int NPOS = 2 * POINTS - 1;
    localparam int AW   = $clog2(NPOS);
    localparam int OW   = $clog2(POINTS + 1);

    logic          r_interp;
    logic          n_interp;
    logic [7:0]    r_step;
    logic [7:0]    n_step;
    logic [OW-1:0] r_orig;
    logic [OW-1:0] n_orig;
    logic          r_out_valid;
    t_out_beat     r_out_data;

    logic          accept;
    logic          emit;
    logic [AW-1:0] rd_addr;
    t_tbl_wr       tbl_wr;
    t_out_beat     point;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign tbl_wr = '{strobe: accept && (i_in_data.mode == MODE_BYTE),
                      last:   i_in_data.last_byte,
                      data:   i_in_data.data_byte};

    assign rd_addr = r_interp ? r_step[AW-1:0] : AW'({r_orig, 1'b0});

    always_comb begin
        n_interp = r_interp;
        n_step   = r_step;
        n_orig   = r_orig;
        emit     = 1'b0;
        if (accept) begin
            case (i_in_data.mode)
                MODE_BYTE: begin
                    if (i_in_data.last_byte) begin
                        n_step = '0;
                        n_orig = '0;
                    end
                end
                MODE_FIRE: begin
                    if (r_interp) begin
                        if (r_step < 8'(NPOS)) begin
                            emit   = 1'b1;
                            n_step = r_step + 8'd1;
                        end
                    end else begin
                        if (!r_step[0] && (r_orig < OW'(POINTS))) begin
                            emit   = 1'b1;
                            n_orig = r_orig + 1'b1;
                        end
                        n_step = r_step + 8'd1;
                    end
                end
                MODE_TOGGLE: begin
                    n_interp = !r_interp;
                    n_step   = '0;
                    n_orig   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    gpi_point_table #(
        .POINTS (POINTS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_addr (rd_addr),
        .o_point   (point)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp    <= 1'b1;
            r_step      <= '0;
            r_orig      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_interp <= n_interp;
            r_step   <= n_step;
            r_orig   <= n_orig;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= point;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_orig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_orig <= OW'(POINTS))
        else $error("original index beyond point count");

    a_interp_orig_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_interp |-> r_orig == '0)
        else $error("original index moved in interpolated mode");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> o_out_valid && o_out_data == $past(point))
        else $error("emitted point not presented");

    a_toggle_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_data.mode == MODE_TOGGLE |=> r_step == '0 && r_orig == '0)
        else $error("mode toggle left counters set");
`endif

endmodule

[test/galvo_point_interpolator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// galvo_point_interpolator_checker
// Watches both beat channels of the interpolator, keeps its own copy of the
// packet staging, point stores and tick counters, predicts every emitted
// point and compares it field by field with what the block hands out.
// ----------------------------------------------------------------------------
module galvo_point_interpolator_checker
    import gpi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int NUM_BYTES = 3 * POINTS_DEF;
    localparam int NUM_POS   = 2 * POINTS_DEF - 1;

    logic [7:0]  staged [NUM_BYTES];
    int unsigned byte_pos;
    logic [7:0]  store_x [POINTS_DEF];
    logic [7:0]  store_y [POINTS_DEF];
    logic [7:0]  store_laser [POINTS_DEF];
    bit          interp_on;
    logic [7:0]  step_cnt;
    int unsigned orig_idx;

    t_out_beat   expected_points [$];
    int          fails;

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic clear_model();
        for (int i = 0; i < NUM_BYTES; i++) staged[i] = '0;
        for (int i = 0; i < POINTS_DEF; i++) begin
            store_x[i]     = '0;
            store_y[i]     = '0;
            store_laser[i] = '0;
        end
        byte_pos  = 0;
        interp_on = 1'b1;
        step_cnt  = '0;
        orig_idx  = 0;
    endtask

    task automatic predict_point(input t_in_beat b, output bit hit, output t_out_beat pt);
        int          p;
        logic [8:0]  sum_x;
        logic [8:0]  sum_y;
        hit = 1'b0;
        pt  = '0;
        case (b.mode)
            MODE_BYTE: begin
                if (byte_pos < NUM_BYTES) begin
                    staged[byte_pos] = b.data_byte;
                    byte_pos++;
                end
                if (b.last_byte) begin
                    for (int i = 0; i < POINTS_DEF; i++) begin
                        store_x[i]     = staged[3 * i];
                        store_y[i]     = staged[3 * i + 1];
                        store_laser[i] = staged[3 * i + 2];
                    end
                    byte_pos = 0;
                    step_cnt = '0;
                    orig_idx = 0;
                end
            end
            MODE_FIRE: begin
                if (interp_on) begin
                    if (step_cnt < NUM_POS) begin
                        p = step_cnt >> 1;
                        if (!step_cnt[0]) begin
                            pt.x_value     = store_x[p];
                            pt.y_value     = store_y[p];
                            pt.laser_value = store_laser[p];
                        end else begin
                            sum_x          = {1'b0, store_x[p]} + {1'b0, store_x[p + 1]};
                            sum_y          = {1'b0, store_y[p]} + {1'b0, store_y[p + 1]};
                            pt.x_value     = sum_x[8:1];
                            pt.y_value     = sum_y[8:1];
                            pt.laser_value = store_laser[p];
                        end
                        hit      = 1'b1;
                        step_cnt = step_cnt + 8'd1;
                    end
                end else begin
                    if (!step_cnt[0] && orig_idx < POINTS_DEF) begin
                        pt.x_value     = store_x[orig_idx];
                        pt.y_value     = store_y[orig_idx];
                        pt.laser_value = store_laser[orig_idx];
                        hit            = 1'b1;
                        orig_idx++;
                    end
                    step_cnt = step_cnt + 8'd1;
                end
            end
            MODE_TOGGLE: begin
                interp_on = !interp_on;
                step_cnt  = '0;
                orig_idx  = 0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        bit        hit;
        t_out_beat pt;
        t_out_beat want;
        if (!i_rst_n) begin
            clear_model();
            expected_points.delete();
        end else begin
            // output side first: a point never leaves in the cycle of its tick
            if (i_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected point: x=%0d y=%0d laser=%0d",
                                 i_out_data.x_value, i_out_data.y_value,
                                 i_out_data.laser_value);
                end else begin
                    want = expected_points.pop_front();
                    if (i_out_data.x_value !== want.x_value ||
                        i_out_data.y_value !== want.y_value ||
                        i_out_data.laser_value !== want.laser_value) begin
                        fails++;
                        if (fails <= 10)
                            $display("point mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.x_value, want.y_value, want.laser_value,
                                     i_out_data.x_value, i_out_data.y_value,
                                     i_out_data.laser_value);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_point(i_in_data, hit, pt);
                if (hit) expected_points.push_back(pt);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_points.size();
    end

endmodule

[test/tb_galvo_point_interpolator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_galvo_point_interpolator_unit
// Drives packets, fire ticks, mode toggles and stray beats into the galvo
// point interpolator under several idling patterns on both channels; the
// checker beside the block predicts and compares every emitted point.
// ----------------------------------------------------------------------------
module tb_galvo_point_interpolator_unit;
    import gpi_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    int        fail_count;
    int        pending;
    int        sender_idle_pct;
    int        recv_stall_pct;
    int        beats_sent;
    int        quiet_cycles;

    galvo_point_interpolator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    galvo_point_interpolator_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    function automatic t_in_beat make_beat(logic [1:0] mode, logic [7:0] data, logic last);
        t_in_beat b;
        b.mode      = mode;
        b.data_byte = data;
        b.last_byte = last;
        return b;
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(15);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_beat(input t_in_beat b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_beat(make_beat(MODE_FIRE, rand_byte(), 1'($urandom_range(1))));
    endtask

    task automatic run_directed();
        logic [7:0] pkt [16];
        pkt = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128,
                8'd1, 8'd255, 8'd255, 8'd254, 8'd1, 8'd0, 8'd255, 8'd77};
        // tick on empty stores
        send_beat(make_beat(MODE_FIRE, 8'd0, 1'b0));
        // overlong packet: the sixteenth byte is dropped but still commits
        for (int i = 0; i < 16; i++)
            send_beat(make_beat(MODE_BYTE, pkt[i], i == 15));
        send_beat(make_beat(MODE_FIRE, 8'd0, 1'b0));
        send_beat(make_beat(MODE_FIRE, 8'd0, 1'b0));
        send_beat(make_beat(MODE_FIRE, 8'd0, 1'b0));
        send_beat(make_beat(MODE_TOGGLE, 8'd0, 1'b0));
        send_beat(make_beat(MODE_FIRE, 8'd0, 1'b0));
        send_beat(make_beat(MODE_FIRE, 8'd255, 1'b1));
        send_beat(make_beat(MODE_FIRE, 8'd0, 1'b0));
        // unused selector with last flag set
        send_beat(make_beat(2'd3, 8'd255, 1'b1));
        // short packet: only the first byte is replaced
        send_beat(make_beat(MODE_BYTE, 8'd200, 1'b1));
        send_beat(make_beat(MODE_TOGGLE, 8'd255, 1'b1));
    endtask

    task automatic run_random(input int target);
        int r;
        int len;
        int stop_at;
        stop_at = beats_sent + target;
        while (beats_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 35) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(1, 18) : 3 * POINTS_DEF;
                for (int i = 0; i < len; i++)
                    send_beat(make_beat(MODE_BYTE, rand_byte(), i == len - 1));
                send_ticks($urandom_range(1, 12));
            end else if (r < 70) begin
                send_ticks($urandom_range(1, 14));
            end else if (r < 80) begin
                send_beat(make_beat(MODE_TOGGLE, rand_byte(), 1'($urandom_range(1))));
            end else if (r < 92) begin
                send_beat(make_beat(2'($urandom_range(3)), rand_byte(),
                                    1'($urandom_range(1))));
            end else begin
                // partial packet left open
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_beat(make_beat(MODE_BYTE, rand_byte(), 1'b0));
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        i_out_ready     = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        beats_sent      = 0;
        quiet_cycles    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(360);
        sender_idle_pct = 48;
        run_random(360);
        sender_idle_pct = 0;
        recv_stall_pct  = 48;
        run_random(360);
        sender_idle_pct = 38;
        recv_stall_pct  = 38;
        run_random(360);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[sim.f]
src/gpi_pkg.sv
src/gpi_point_table.sv
src/galvo_point_interpolator_unit.sv
test/galvo_point_interpolator_checker.sv
test/tb_galvo_point_interpolator_unit.sv
